>>> sv/srgbds_pkg.sv
// shared types, register codes and conversion tables for the srgb box downsampler
package srgbds_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_HEIGHT = 2'd1;

    localparam int LIN_W     = 17;
    localparam int IDX_W     = 13;
    localparam int SRGB_LAST = 4096;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       level_done;
    } pixel_out_t;

    // one pixel in linear light
    typedef struct packed {
        logic [LIN_W-1:0] red;
        logic [LIN_W-1:0] green;
        logic [LIN_W-1:0] blue;
        logic [7:0]       alpha;
    } lin_t;

    // horizontal pair sum
    typedef struct packed {
        logic [LIN_W:0] red;
        logic [LIN_W:0] green;
        logic [LIN_W:0] blue;
        logic [8:0]     alpha;
    } pair_t;

    typedef struct packed {
        logic hold_load;
        logic pair_self;
        logic wr;
        logic emit;
        logic done;
        logic h1;
    } ctl_t;

    // block result ready for the output table
    typedef struct packed {
        logic [IDX_W-1:0] red;
        logic [IDX_W-1:0] green;
        logic [IDX_W-1:0] blue;
        logic [7:0]       alpha;
        logic             done;
    } enc_t;

    typedef logic [255:0][LIN_W-1:0] lin_table_t;
    typedef logic [SRGB_LAST:0][7:0] srgb_table_t;

    // srgb byte to linear q1.16, exact integer rounding
    function automatic lin_table_t build_lin_table();
        lin_table_t   t;
        logic [255:0] base;
        logic [255:0] lhs;
        logic [255:0] rhs;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        t = '0;
        base = 256'd1;
        for (int n = 0; n < 12; n++)
        begin
            base = base * 256'd10761;
        end
        for (int unsigned v = 0; v < 256; v++)
        begin
            if (v <= 10)
            begin
                t[v] = LIN_W'((64'd13107200 * 64'(v) + 64'd329460) / 64'd658920);
            end
            else
            begin
                rhs = 256'd1;
                for (int n = 0; n < 12; n++)
                begin
                    rhs = rhs * 256'(40 * v + 561);
                end
                for (int n = 0; n < 5; n++)
                begin
                    rhs = rhs * 256'd131072;
                end
                lo = 1;
                hi = 65536;
                while (lo < hi)
                begin
                    mid = (lo + hi + 1) >> 1;
                    lhs = base;
                    for (int n = 0; n < 5; n++)
                    begin
                        lhs = lhs * 256'(2 * mid - 1);
                    end
                    if (lhs <= rhs)
                        lo = mid;
                    else
                        hi = mid - 1;
                end
                t[v] = LIN_W'(lo);
            end
        end
        return t;
    endfunction

    // linear index (0..4096) to srgb byte, round to nearest
    function automatic srgb_table_t build_srgb_table();
        srgb_table_t  t;
        logic [255:0] kb [256];
        logic [255:0] base;
        logic [255:0] lhs;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        t = '0;
        kb[0] = '0;
        for (int unsigned k = 1; k < 256; k++)
        begin
            kb[k] = 256'd1;
            for (int n = 0; n < 12; n++)
            begin
                kb[k] = kb[k] * 256'(200 * k + 2705);
            end
            for (int n = 0; n < 5; n++)
            begin
                kb[k] = kb[k] * 256'd4096;
            end
        end
        base = 256'd1;
        for (int n = 0; n < 12; n++)
        begin
            base = base * 256'd53805;
        end
        for (int unsigned i = 0; i <= SRGB_LAST; i++)
        begin
            if (i <= 12)
            begin
                t[i] = 8'((32946 * i + 20480) / 40960);
            end
            else
            begin
                lhs = base;
                for (int n = 0; n < 5; n++)
                begin
                    lhs = lhs * 256'(i);
                end
                lo = 0;
                hi = 255;
                while (lo < hi)
                begin
                    mid = (lo + hi + 1) >> 1;
                    if (kb[mid] <= lhs)
                        lo = mid;
                    else
                        hi = mid - 1;
                end
                t[i] = 8'(lo);
            end
        end
        return t;
    endfunction

    localparam lin_table_t  LIN_TABLE  = build_lin_table();
    localparam srgb_table_t SRGB_TABLE = build_srgb_table();

endpackage

>>> sv/srgb_linear_box_downsample.sv
// srgb-correct 2x2 box downsampler: one mip level in, half-size level out
// latency: a block result passes the linearize, pair, index and output registers
// throughput: one pixel per clock unless stalled, set by the pair store's single ports
// a 2x2 block gives one result on its odd row (every row at height 1); others give none
// reset: width and height 1, position at the first pixel, held pixel zero
// the pair store is not cleared; each entry is written on an even row before it is read
module srgb_linear_box_downsample #(
    parameter  int MAX_WIDTH  = 4096,
    localparam int PAIR_DEPTH = MAX_WIDTH / 2,
    localparam int AW         = $clog2(PAIR_DEPTH > 1 ? PAIR_DEPTH : 2)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [srgbds_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [srgbds_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  srgbds_pkg::pixel_in_t               in_pixel,
    output logic                                out_valid,
    input  logic                                out_stall,
    output srgbds_pkg::pixel_out_t              out_pixel
);
    import srgbds_pkg::*;

    logic           restart;
    logic           lin_valid;
    logic           lin_ready;
    lin_t           lin_item;
    ctl_t           lin_ctl;
    logic [AW-1:0]  lin_pidx;
    logic           enc_valid;
    logic           enc_ready;
    enc_t           enc_item;

    srgbds_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .restart   (restart),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_pixel  (in_pixel),
        .lin_valid (lin_valid),
        .lin_ready (lin_ready),
        .lin_item  (lin_item),
        .lin_ctl   (lin_ctl),
        .lin_pidx  (lin_pidx)
    );

    srgbds_pair #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_pair (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (restart),
        .lin_valid (lin_valid),
        .lin_ready (lin_ready),
        .lin_item  (lin_item),
        .lin_ctl   (lin_ctl),
        .lin_pidx  (lin_pidx),
        .enc_valid (enc_valid),
        .enc_ready (enc_ready),
        .enc_item  (enc_item)
    );

    srgbds_encode u_encode (
        .clk       (clk),
        .rst_n     (rst_n),
        .enc_valid (enc_valid),
        .enc_ready (enc_ready),
        .enc_item  (enc_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_pixel (out_pixel)
    );

endmodule

>>> sv/srgbds_ram.sv
// generic single-write, single-read synchronous ram with registered read
module srgbds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

>>> sv/srgbds_front.sv
// level registers, pixel position counters and linearizing input stage
module srgbds_front #(
    parameter  int MAX_WIDTH  = 4096,
    localparam int PAIR_DEPTH = MAX_WIDTH / 2,
    localparam int AW         = $clog2(PAIR_DEPTH > 1 ? PAIR_DEPTH : 2)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [srgbds_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [srgbds_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                                restart,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  srgbds_pkg::pixel_in_t               in_pixel,
    output logic                                lin_valid,
    input  logic                                lin_ready,
    output srgbds_pkg::lin_t                    lin_item,
    output srgbds_pkg::ctl_t                    lin_ctl,
    output logic [AW-1:0]                       lin_pidx
);
    import srgbds_pkg::*;

    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (WW > 13) ? WW : 13;
    localparam int XW   = ($clog2(MAX_WIDTH) > AW + 1) ? $clog2(MAX_WIDTH) : AW + 1;

    logic [XW-1:0]  w_m1_reg;
    logic           w1_reg;
    logic [AW-1:0]  nw_m1_reg;
    logic [15:0]    h_m1_reg;
    logic           h1_reg;
    logic [14:0]    last_rp_reg;
    logic [XW-1:0]  col_reg;
    logic [15:0]    row_reg;

    logic           cfg_wr;
    logic           accept;
    logic [CMPW-1:0] w_ext;
    logic [CMPW-1:0] w_eff;
    logic [15:0]    h_eff;
    logic           have_pair;
    logic           even_row;
    logic [AW-1:0]  pidx;
    ctl_t           ctl_next;

    logic           s1_valid_reg;
    lin_t           s1_item_reg;
    ctl_t           s1_ctl_reg;
    logic [AW-1:0]  s1_pidx_reg;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign restart   = cfg_wr && (cfg_index == REG_LEVEL_WIDTH || cfg_index == REG_LEVEL_HEIGHT);

    // zero means one, anything past the line store means the line store
    assign w_ext = CMPW'(cfg_data[12:0]);
    always_comb
    begin
        if (w_ext == '0)
            w_eff = CMPW'(1);
        else if (w_ext > CMPW'(MAX_WIDTH))
            w_eff = CMPW'(MAX_WIDTH);
        else
            w_eff = w_ext;
    end
    assign h_eff = (cfg_data == '0) ? 16'd1 : cfg_data;

    assign in_stall = s1_valid_reg && !lin_ready;
    assign accept   = in_valid && !in_stall;

    assign have_pair = w1_reg || col_reg[0];
    assign even_row  = !row_reg[0];
    assign pidx      = AW'(col_reg >> 1);

    always_comb
    begin
        ctl_next.hold_load = !w1_reg && !col_reg[0];
        ctl_next.pair_self = w1_reg;
        ctl_next.wr        = have_pair && !h1_reg && even_row;
        ctl_next.emit      = have_pair && (h1_reg || !even_row);
        ctl_next.done      = have_pair && (h1_reg || !even_row) && pidx == nw_m1_reg
                             && (h1_reg || row_reg[15:1] == last_rp_reg);
        ctl_next.h1        = h1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_m1_reg     <= '0;
            w1_reg       <= 1'b1;
            nw_m1_reg    <= '0;
            h_m1_reg     <= '0;
            h1_reg       <= 1'b1;
            last_rp_reg  <= '1;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (cfg_index)
                    REG_LEVEL_WIDTH:
                    begin
                        w_m1_reg  <= XW'(w_eff - CMPW'(1));
                        w1_reg    <= (w_eff == CMPW'(1));
                        nw_m1_reg <= (w_eff > CMPW'(1)) ? AW'((w_eff >> 1) - CMPW'(1)) : '0;
                    end
                    REG_LEVEL_HEIGHT:
                    begin
                        h_m1_reg    <= h_eff - 16'd1;
                        h1_reg      <= (h_eff == 16'd1);
                        last_rp_reg <= 15'((h_eff >> 1) - 16'd1);
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (restart)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (accept)
            begin
                if (col_reg == w_m1_reg)
                begin
                    col_reg <= '0;
                    row_reg <= (row_reg == h_m1_reg) ? 16'd0 : row_reg + 16'd1;
                end
                else
                begin
                    col_reg <= col_reg + XW'(1);
                end
            end
            if (!in_stall)
                s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg.red   <= LIN_TABLE[in_pixel.red];
            s1_item_reg.green <= LIN_TABLE[in_pixel.green];
            s1_item_reg.blue  <= LIN_TABLE[in_pixel.blue];
            s1_item_reg.alpha <= in_pixel.alpha;
            s1_ctl_reg        <= ctl_next;
            s1_pidx_reg       <= pidx;
        end
    end

    assign lin_valid = s1_valid_reg;
    assign lin_item  = s1_item_reg;
    assign lin_ctl   = s1_ctl_reg;
    assign lin_pidx  = s1_pidx_reg;

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= w_m1_reg)
        else $error("column counter past level width");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= h_m1_reg)
        else $error("row counter past level height");

endmodule

>>> sv/srgbds_pair.sv
// horizontal pairing, row pair store read-modify and block sum to table index
module srgbds_pair #(
    parameter  int MAX_WIDTH  = 4096,
    localparam int PAIR_DEPTH = MAX_WIDTH / 2,
    localparam int AW         = $clog2(PAIR_DEPTH > 1 ? PAIR_DEPTH : 2)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                restart,
    input  logic                lin_valid,
    output logic                lin_ready,
    input  srgbds_pkg::lin_t    lin_item,
    input  srgbds_pkg::ctl_t    lin_ctl,
    input  logic [AW-1:0]       lin_pidx,
    output logic                enc_valid,
    input  logic                enc_ready,
    output srgbds_pkg::enc_t    enc_item
);
    import srgbds_pkg::*;

    lin_t           hold_reg;
    pair_t          pair_next;
    logic           take;

    logic           ram_we;
    logic [AW-1:0]  ram_raddr;
    logic [$bits(pair_t)-1:0] ram_rdata;
    pair_t          above;

    logic           s2_valid_reg;
    pair_t          s2_pair_reg;
    logic           s2_h1_reg;
    logic           s2_done_reg;
    logic [AW-1:0]  s2_pidx_reg;
    logic           s2_ready;
    logic           s3_valid_reg;
    enc_t           s3_item_reg;
    logic           s3_ready;

    logic [LIN_W+1:0] sum_r;
    logic [LIN_W+1:0] sum_g;
    logic [LIN_W+1:0] sum_b;
    logic [9:0]       sum_a;
    enc_t             enc_next;

    function automatic logic [IDX_W-1:0] to_index(input logic [LIN_W+1:0] s);
        logic [LIN_W+1:0] r;
        r = (s + (LIN_W+2)'(32)) >> 6;
        if (r > (LIN_W+2)'(SRGB_LAST))
            r = (LIN_W+2)'(SRGB_LAST);
        return IDX_W'(r);
    endfunction

    assign s3_ready  = !s3_valid_reg || enc_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign lin_ready = s2_ready;
    assign take      = lin_valid && s2_ready;

    always_comb
    begin
        pair_next.red   = (LIN_W+1)'(lin_item.red)
                          + (LIN_W+1)'(lin_ctl.pair_self ? lin_item.red : hold_reg.red);
        pair_next.green = (LIN_W+1)'(lin_item.green)
                          + (LIN_W+1)'(lin_ctl.pair_self ? lin_item.green : hold_reg.green);
        pair_next.blue  = (LIN_W+1)'(lin_item.blue)
                          + (LIN_W+1)'(lin_ctl.pair_self ? lin_item.blue : hold_reg.blue);
        pair_next.alpha = 9'(lin_item.alpha)
                          + 9'(lin_ctl.pair_self ? lin_item.alpha : hold_reg.alpha);
    end

    // while the stage holds, keep re-reading its entry so the data stays put
    assign ram_we    = take && lin_ctl.wr;
    assign ram_raddr = take ? lin_pidx : s2_pidx_reg;

    srgbds_ram #(
        .WIDTH ($bits(pair_t)),
        .DEPTH (PAIR_DEPTH)
    ) u_pair_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (lin_pidx),
        .wdata (pair_next),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign above = pair_t'(ram_rdata);

    always_comb
    begin
        if (s2_h1_reg)
        begin
            sum_r = (LIN_W+2)'(s2_pair_reg.red) << 1;
            sum_g = (LIN_W+2)'(s2_pair_reg.green) << 1;
            sum_b = (LIN_W+2)'(s2_pair_reg.blue) << 1;
            sum_a = 10'(s2_pair_reg.alpha) << 1;
        end
        else
        begin
            sum_r = (LIN_W+2)'(s2_pair_reg.red) + (LIN_W+2)'(above.red);
            sum_g = (LIN_W+2)'(s2_pair_reg.green) + (LIN_W+2)'(above.green);
            sum_b = (LIN_W+2)'(s2_pair_reg.blue) + (LIN_W+2)'(above.blue);
            sum_a = 10'(s2_pair_reg.alpha) + 10'(above.alpha);
        end
        enc_next.red   = to_index(sum_r);
        enc_next.green = to_index(sum_g);
        enc_next.blue  = to_index(sum_b);
        enc_next.alpha = 8'((sum_a + 10'd2) >> 2);
        enc_next.done  = s2_done_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg     <= '0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (restart)
                hold_reg <= '0;
            else if (take && lin_ctl.hold_load)
                hold_reg <= lin_item;
            // only block-finishing requests move on
            if (s2_ready)
                s2_valid_reg <= lin_valid && lin_ctl.emit;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s2_pair_reg <= pair_next;
            s2_h1_reg   <= lin_ctl.h1;
            s2_done_reg <= lin_ctl.done;
            s2_pidx_reg <= lin_pidx;
        end
        if (s3_ready && s2_valid_reg)
            s3_item_reg <= enc_next;
    end

    assign enc_valid = s3_valid_reg;
    assign enc_item  = s3_item_reg;

    a_held_read_stable: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(s2_valid_reg && !s3_ready) && s2_valid_reg && !s2_h1_reg)
        |-> $stable(ram_rdata))
        else $error("pair store data moved under a held request");

endmodule

>>> sv/srgbds_encode.sv
// linear to srgb table lookup into the output register
module srgbds_encode (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    enc_valid,
    output logic                    enc_ready,
    input  srgbds_pkg::enc_t        enc_item,
    output logic                    out_valid,
    input  logic                    out_stall,
    output srgbds_pkg::pixel_out_t  out_pixel
);
    import srgbds_pkg::*;

    logic       out_valid_reg;
    pixel_out_t out_pixel_reg;

    assign enc_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (enc_ready)
            out_valid_reg <= enc_valid;
    end

    always_ff @(posedge clk)
    begin
        if (enc_ready && enc_valid)
        begin
            out_pixel_reg.out_red    <= SRGB_TABLE[enc_item.red];
            out_pixel_reg.out_green  <= SRGB_TABLE[enc_item.green];
            out_pixel_reg.out_blue   <= SRGB_TABLE[enc_item.blue];
            out_pixel_reg.out_alpha  <= enc_item.alpha;
            out_pixel_reg.level_done <= enc_item.done;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        enc_valid && enc_ready |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

>>> bench/srgb_linear_box_downsample_test.sv
// testbench for the srgb box downsampler: predicts every 2x2 block result and checks it
module srgb_linear_box_downsample_test;

    import srgbds_pkg::*;

    localparam int WIDTH_LIMIT   = 4096;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 1000;

    // index that selects no register
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    typedef struct {
        int unsigned r;
        int unsigned g;
        int unsigned b;
        int unsigned a;
    } lin_sum_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_LEVEL_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    pixel_in_t              in_pixel = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    pixel_out_t             out_pixel;

    // conversion tables of the predictor
    int unsigned  lin_lut [256];
    logic [7:0]   srgb_lut [4097];
    logic [255:0] lin_scale_pow;

    // predictor state
    int unsigned  lvl_width = 1;
    int unsigned  lvl_height = 1;
    int unsigned  col_pos = 0;
    int unsigned  row_pos = 0;
    lin_sum_t     left_hold = '{default: 0};
    lin_sum_t     pair_store [WIDTH_LIMIT / 2];
    pixel_out_t   pending_blocks [$];

    bit           calm = 1'b0;
    int unsigned  mismatches = 0;
    int unsigned  pixels_sent = 0;
    int unsigned  blocks_checked = 0;
    int unsigned  reg_writes = 0;
    int unsigned  quiet_cycles = 0;

    srgb_linear_box_downsample #(
        .MAX_WIDTH (WIDTH_LIMIT)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_pixel  (in_pixel),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_pixel (out_pixel)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [255:0] wide_pow(input logic [255:0] b, input int n);
        logic [255:0] acc;
        acc = 256'd1;
        repeat (n) acc = acc * b;
        return acc;
    endfunction

    // (2y-1)/131072 <= ((40v+561)/10761)^2.4, cleared of fractions and raised to the 5th
    function automatic bit lin_fits(input int unsigned y, input int unsigned v);
        return wide_pow(256'(2 * y - 1), 5) * lin_scale_pow
               <= (wide_pow(256'(40 * v + 561), 12) << 85);
    endfunction

    task automatic build_luts();
        logic [255:0] kb [256];
        logic [255:0] srgb_scale_pow;
        logic [255:0] lhs;
        int unsigned  est;
        int unsigned  k;
        real          x;
        lin_scale_pow = wide_pow(256'd10761, 12);
        for (int unsigned v = 0; v < 256; v++)
        begin
            if (v <= 10)
            begin
                lin_lut[v] = (655360 * v + 16473) / 32946;
            end
            else
            begin
                // float estimate, then exact correction
                x = (v / 255.0 + 0.055) / 1.055;
                est = $rtoi(65536.0 * $pow(x, 2.4) + 0.5);
                if (est < 1)
                    est = 1;
                if (est > 65536)
                    est = 65536;
                while (est < 65536 && lin_fits(est + 1, v))
                    est++;
                while (est > 1 && !lin_fits(est, v))
                    est--;
                lin_lut[v] = est;
            end
        end
        // k passes at index i when (200k+2705)^12 * 4096^5 <= 53805^12 * i^5
        kb[0] = '0;
        for (int unsigned j = 1; j < 256; j++)
            kb[j] = wide_pow(256'(200 * j + 2705), 12) << 60;
        srgb_scale_pow = wide_pow(256'd53805, 12);
        k = 0;
        for (int unsigned i = 0; i <= 4096; i++)
        begin
            if (i <= 12)
            begin
                srgb_lut[i] = 8'((16473 * i + 10240) / 20480);
            end
            else
            begin
                lhs = wide_pow(256'(i), 5) * srgb_scale_pow;
                while (k < 255 && kb[k + 1] <= lhs)
                    k++;
                srgb_lut[i] = 8'(k);
            end
        end
    endtask

    function automatic int unsigned clamp_width(input int unsigned w);
        return (w < 1) ? 1 : (w > WIDTH_LIMIT) ? WIDTH_LIMIT : w;
    endfunction

    function automatic int unsigned clamp_height(input int unsigned h);
        return (h < 1) ? 1 : h;
    endfunction

    function automatic lin_sum_t sum_lin(input lin_sum_t p, input lin_sum_t q);
        lin_sum_t s;
        s.r = p.r + q.r;
        s.g = p.g + q.g;
        s.b = p.b + q.b;
        s.a = p.a + q.a;
        return s;
    endfunction

    function automatic logic [7:0] srgb_byte(input int unsigned sum);
        int unsigned idx;
        idx = (sum + 32) >> 6;
        if (idx > 4096)
            idx = 4096;
        return srgb_lut[idx];
    endfunction

    task automatic apply_level_reg(input logic [CFG_INDEX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_LEVEL_WIDTH:  lvl_width = data & 16'h1FFF;
            REG_LEVEL_HEIGHT: lvl_height = data;
            default:          return;
        endcase
        col_pos = 0;
        row_pos = 0;
        left_hold = '{default: 0};
    endtask

    // moves the level position by one pixel and queues the block it finishes, if any
    task automatic advance_downsampler(input pixel_in_t px);
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        int unsigned pidx;
        int unsigned nw;
        lin_sum_t    cur;
        lin_sum_t    pair;
        lin_sum_t    blk;
        bit          have_pair;
        bit          emit;
        pixel_out_t  res;
        w = clamp_width(lvl_width);
        h = clamp_height(lvl_height);
        x = col_pos;
        y = row_pos;
        have_pair = 1'b0;
        emit = 1'b0;
        cur.r = lin_lut[px.red];
        cur.g = lin_lut[px.green];
        cur.b = lin_lut[px.blue];
        cur.a = px.alpha;
        pair = cur;
        if (w == 1)
        begin
            pair = sum_lin(cur, cur);
            have_pair = 1'b1;
        end
        else if (x[0] == 1'b0)
        begin
            left_hold = cur;
        end
        else
        begin
            pair = sum_lin(left_hold, cur);
            have_pair = 1'b1;
        end
        pidx = x >> 1;
        blk = pair;
        if (have_pair && pidx < WIDTH_LIMIT / 2)
        begin
            if (h == 1)
            begin
                blk = sum_lin(pair, pair);
                emit = 1'b1;
            end
            else if (y[0] == 1'b0)
            begin
                pair_store[pidx] = pair;
            end
            else
            begin
                blk = sum_lin(pair_store[pidx], pair);
                emit = 1'b1;
            end
        end
        nw = (w > 1) ? (w >> 1) : 1;
        if (x + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (y + 1 >= h) ? 0 : y + 1;
        end
        else
        begin
            col_pos = x + 1;
        end
        if (emit)
        begin
            res.out_red    = srgb_byte(blk.r);
            res.out_green  = srgb_byte(blk.g);
            res.out_blue   = srgb_byte(blk.b);
            res.out_alpha  = 8'((blk.a + 2) >> 2);
            res.level_done = (pidx == nw - 1) && (h == 1 || (y >> 1) == (h >> 1) - 1);
            pending_blocks.insert(pending_blocks.size(), res);
        end
    endtask

    function automatic logic [7:0] random_byte();
        int unsigned pick;
        pick = $urandom_range(9);
        return (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
    endfunction

    function automatic pixel_in_t random_pixel();
        pixel_in_t p;
        p.red   = random_byte();
        p.green = random_byte();
        p.blue  = random_byte();
        p.alpha = random_byte();
        return p;
    endfunction

    // valid stays high after the request is taken; settle_block lowers it
    task automatic send_pixel(input pixel_in_t px);
        bit taken;
        if (!calm && $urandom_range(99) < 16)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < 16);
        end
        in_valid <= 1'b1;
        in_pixel <= px;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        advance_downsampler(px);
        pixels_sent++;
    endtask

    task automatic settle_block();
        in_valid <= 1'b0;
        while (pending_blocks.size() != 0)
            @(posedge clk);
        // requests that finish no block may still be in the pipe
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        apply_level_reg(idx, data);
        reg_writes++;
    endtask

    task automatic program_level(input logic [CFG_DATA_W-1:0] w,
                                 input logic [CFG_DATA_W-1:0] h);
        settle_block();
        write_reg(REG_LEVEL_WIDTH, w);
        write_reg(REG_LEVEL_HEIGHT, h);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_level(input logic [CFG_DATA_W-1:0] w,
                             input logic [CFG_DATA_W-1:0] h,
                             input int unsigned count);
        program_level(w, h);
        repeat (count) send_pixel(random_pixel());
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_block(input pixel_out_t got);
        pixel_out_t want;
        if (pending_blocks.size() == 0)
        begin
            $error("block result with none expected: %h", got);
            mismatches++;
            return;
        end
        want = pending_blocks.pop_front();
        compare_field("out_red", want.out_red, got.out_red);
        compare_field("out_green", want.out_green, got.out_green);
        compare_field("out_blue", want.out_blue, got.out_blue);
        compare_field("out_alpha", want.out_alpha, got.out_alpha);
        compare_field("level_done", 8'(want.level_done), 8'(got.level_done));
        blocks_checked++;
    endtask

    // default 1x1 after reset: every pixel is its own block
    task automatic test_unit_level();
        send_pixel('{red: 8'h00, green: 8'h00, blue: 8'h00, alpha: 8'h00});
        send_pixel('{red: 8'hFF, green: 8'hFF, blue: 8'hFF, alpha: 8'hFF});
        send_pixel('{red: 8'd10, green: 8'd11, blue: 8'd12, alpha: 8'd13});
        send_pixel('{red: 8'd11, green: 8'd10, blue: 8'hFF, alpha: 8'h01});
        send_pixel('{red: 8'h55, green: 8'hAA, blue: 8'h01, alpha: 8'hFE});
    endtask

    // odd last column and odd last row are dropped
    task automatic test_odd_edges();
        run_level(16'd3, 16'd3, 9);
    endtask

    task automatic test_spare_index_and_restart();
        run_level(16'd4, 16'd2, 6);
        // hold the sender until the pending block is out
        settle_block();
        write_reg(REG_SPARE, 16'hFFFF);
        cfg_valid <= 1'b0;
        // the spare write must not move the level position
        repeat (2) send_pixel(random_pixel());
        repeat (3) send_pixel(random_pixel());
        // restart in the middle of a level
        run_level(16'd2, 16'd2, 4);
    endtask

    task automatic test_size_sweep();
        run_level(16'd0, 16'd0, 3);
        run_level(16'hFFFF, 16'd1, 256);
        run_level(16'd4096, 16'd2, 128);
        run_level(16'd1, 16'hFFFF, 100);
        run_level(16'h2003, 16'h8002, 60);
        run_level(16'd5, 16'd1, 10);
        run_level(16'd1, 16'd6, 12);
        run_level(16'd7, 16'd5, 70);
        run_level(16'd2, 16'd2, 8);
    endtask

    // mostly whole levels of small sizes, some cut short by a new setting
    task automatic test_random_levels(input int unsigned budget);
        int unsigned sent;
        int unsigned w;
        int unsigned h;
        int unsigned n;
        sent = 0;
        while (sent < budget)
        begin
            w = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            h = $urandom_range(0, 9);
            n = clamp_width(w) * clamp_height(h) * $urandom_range(1, 2);
            if ($urandom_range(99) < 15)
                n = $urandom_range(1, n);
            if (n > budget - sent)
                n = budget - sent;
            program_level(16'(w), 16'(h));
            for (int k = 0; k < n; k++)
            begin
                if (k == n / 2 && $urandom_range(19) == 0)
                    settle_block();
                send_pixel(random_pixel());
            end
            sent += n;
        end
    endtask

    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(99) < 16);

    always
    begin
        bit         took;
        pixel_out_t got;
        @(negedge clk);
        took = rst_n && out_valid && !out_stall;
        got = out_pixel;
        @(posedge clk);
        if (took)
            check_block(got);
    end

    always @(negedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $error("no request moved for %0d cycles, %0d blocks outstanding",
                   quiet_cycles, pending_blocks.size());
            $display("srgb_linear_box_downsample_test NOT OK");
            $finish;
        end
    end

    initial
    begin
        build_luts();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_unit_level();
        test_odd_edges();
        test_spare_index_and_restart();
        test_size_sweep();
        test_random_levels(900);
        calm = 1'b1;
        test_random_levels(274);
        calm = 1'b0;
        settle_block();
        $display("sent %0d pixels over %0d register writes, checked %0d blocks",
                 pixels_sent, reg_writes, blocks_checked);
        $display("levels from 1x1 up to 4096 wide and 65535 high, with restarts");
        if (mismatches == 0)
            $display("srgb_linear_box_downsample_test OK");
        else
            $display("srgb_linear_box_downsample_test NOT OK");
        $finish;
    end

endmodule
